FILE: rtl/mma_pkg.sv
// shared types, widths, codes and saturation helper for the matrix multiply-accumulate
// no dependencies
package mma_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int POS_REACH   = 8;
    localparam int EL_W        = 16;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 32;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 48;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FUNC_W-1:0] FN_LOAD_A   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_B   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PRESET_C = 2'd2;
    localparam logic [FUNC_W-1:0] FN_START    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;

    typedef struct packed {
        logic             v;
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] k;
        logic [EL_W-1:0]  a;
    } t_link;

    typedef struct packed {
        logic             b_we;
        logic             c_we;
        logic [POS_W-1:0] wr_row;
        logic [POS_W-1:0] wr_col;
        logic [EL_W-1:0]  element;
        logic [ACC_W-1:0] acc_init;
        logic [DIM_W-1:0] cols;
        logic [POS_W-1:0] rd_row;
    } t_cell_ctl;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] c,
                                                 input logic [PROD_W-1:0] p);
        logic [ACC_W:0] s;
        s = {c[ACC_W-1], c} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/mma_cell.sv
// one column cell: holds a column of B and of C, multiplies the passing A element
// depends on mma_pkg
module mma_cell #(
    parameter int NCELL = mma_pkg::MAX_DIM_DEF,
    parameter int J     = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mma_pkg::t_cell_ctl        i_ctl,
    input  mma_pkg::t_link            i_link,
    output mma_pkg::t_link            o_link,
    output logic [mma_pkg::ACC_W-1:0] o_rd
);
    import mma_pkg::*;

    localparam int KW = $clog2(NCELL);

    logic [EL_W-1:0]   b_mem   [NCELL];
    logic [ACC_W-1:0]  c_mem   [NCELL];
    logic [NCELL-1:0]  r_c_valid;
    t_link             r_link;
    logic              r_pv;
    logic [KW-1:0]     r_pi;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic              active;
    logic [KW-1:0]     c_addr;
    logic [ACC_W-1:0]  c_cur;
    logic              own_col;

    assign own_col = (i_ctl.wr_col == POS_W'(J));
    assign active  = (DIM_W'(J) < i_ctl.cols);
    assign n_prod  = PROD_W'($signed(i_link.a) * $signed(b_mem[i_link.k[KW-1:0]]));
    assign c_addr  = r_pv ? r_pi : i_ctl.rd_row[KW-1:0];
    assign c_cur   = r_c_valid[c_addr] ? c_mem[c_addr] : '0;
    assign o_rd    = c_cur;
    assign o_link  = r_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.v  <= 1'b0;
            r_pv      <= 1'b0;
            r_c_valid <= '0;
        end else begin
            r_link.v <= i_link.v;
            r_pv     <= i_link.v && active;
            if (i_ctl.c_we && own_col) begin
                r_c_valid[i_ctl.wr_row[KW-1:0]] <= 1'b1;
            end else if (r_pv) begin
                r_c_valid[r_pi] <= 1'b1;
            end
        end
        r_link.i <= i_link.i;
        r_link.k <= i_link.k;
        r_link.a <= i_link.a;
        r_pi     <= i_link.i[KW-1:0];
        r_prod   <= n_prod;
        if (i_ctl.b_we && own_col) begin
            b_mem[i_ctl.wr_row[KW-1:0]] <= i_ctl.element;
        end
        if (i_ctl.c_we && own_col) begin
            c_mem[i_ctl.wr_row[KW-1:0]] <= i_ctl.acc_init;
        end else if (r_pv) begin
            c_mem[r_pi] <= sat_add(c_cur, r_prod);
        end
    end

endmodule

FILE: rtl/matrix_multiply_accumulate.sv
// top level: A store, sequencer feeding a chain of column cells, result emit
// depends on mma_pkg and mma_cell
// sequence: a start feeds rows*inner A elements, then drains the cell chain, then emits
// one result per cycle (rows*cols) while the output side accepts
// load items are accepted only while idle; the A store read port sets the feed rate
// synchronous active-low reset clears C to zero, configured dimensions to 8, and the valids
module matrix_multiply_accumulate #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mma_pkg::IN_DATA_W-1:0]  i_s_tdata,  // row, col, element, acc_init
    input  logic [mma_pkg::FUNC_W-1:0]     i_s_tuser,  // func
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mma_pkg::OUT_DATA_W-1:0] o_m_tdata,  // out_row, out_col, value
    output logic                           o_m_tlast,
    input  logic                           i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mma_pkg::DIM_W-1:0]      i_cfg_data
);
    import mma_pkg::*;

    localparam int NCELL = (MAX_DIM < POS_REACH) ? MAX_DIM : POS_REACH;
    localparam int KW    = $clog2(NCELL);
    localparam int DRW   = $clog2(NCELL + 4);

    typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN, S_EMIT} t_state;

    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_reg_rows, r_reg_cols, r_reg_inner;
    logic [DIM_W-1:0]  r_rows, r_cols, r_inner, n_rows, n_cols, n_inner;
    logic [POS_W-1:0]  r_i, r_k, n_i, n_k;
    logic [DRW-1:0]    r_drain, n_drain;
    logic              r_feed_v, n_feed_v;
    logic [POS_W-1:0]  r_feed_i, r_feed_k;
    logic [EL_W-1:0]   r_a_rd;
    logic [EL_W-1:0]   a_mem [1 << (2*KW)];
    logic              r_out_v, n_out_v;
    logic              r_out_last, n_out_last;
    logic [POS_W-1:0]  r_out_row, r_out_col, n_out_row, n_out_col;
    logic [ACC_W-1:0]  r_out_val, n_out_val;

    logic [POS_W-1:0]  in_row, in_col;
    logic [EL_W-1:0]   in_el;
    logic [ACC_W-1:0]  in_acc;
    logic              in_ok, accept;
    t_cell_ctl         ctl;
    t_link             links [NCELL+1];
    logic [ACC_W-1:0]  cell_rd [NCELL];

    function automatic logic [DIM_W-1:0] lim(input logic [DIM_W-1:0] v);
        lim = (v > DIM_W'(NCELL)) ? DIM_W'(NCELL) : v;
    endfunction

    assign in_row = i_s_tdata[2:0];
    assign in_col = i_s_tdata[5:3];
    assign in_el  = i_s_tdata[21:6];
    assign in_acc = i_s_tdata[61:22];
    assign in_ok  = (DIM_W'(in_row) < DIM_W'(NCELL)) && (DIM_W'(in_col) < DIM_W'(NCELL));
    assign o_s_tready = (r_state == S_IDLE);
    assign accept = i_s_tvalid && o_s_tready;

    assign ctl.b_we     = accept && in_ok && (i_s_tuser == FN_LOAD_B);
    assign ctl.c_we     = accept && in_ok && (i_s_tuser == FN_PRESET_C);
    assign ctl.wr_row   = in_row;
    assign ctl.wr_col   = in_col;
    assign ctl.element  = in_el;
    assign ctl.acc_init = in_acc;
    assign ctl.cols     = r_cols;
    assign ctl.rd_row   = r_i;

    assign links[0] = '{v: r_feed_v, i: r_feed_i, k: r_feed_k, a: r_a_rd};

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mma_cell #(.NCELL(NCELL), .J(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_link (links[g]),
            .o_link (links[g+1]),
            .o_rd   (cell_rd[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_inner    = r_inner;
        n_i        = r_i;
        n_k        = r_k;
        n_drain    = r_drain;
        n_feed_v   = 1'b0;
        n_out_v    = r_out_v && !i_m_tready;
        n_out_last = r_out_last;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_val  = r_out_val;
        case (r_state)
            S_IDLE: begin
                if (accept && i_s_tuser == FN_START) begin
                    n_rows  = lim(r_reg_rows);
                    n_cols  = lim(r_reg_cols);
                    n_inner = lim(r_reg_inner);
                    n_i     = '0;
                    n_k     = '0;
                    n_drain = DRW'(NCELL + 3);
                    if (n_rows == '0 || n_cols == '0) begin
                        n_state = S_IDLE;
                    end else if (n_inner == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_FEED;
                    end
                end
            end
            S_FEED: begin
                n_feed_v = 1'b1;
                if (DIM_W'(r_k) == r_inner - 1'b1) begin
                    n_k = '0;
                    if (DIM_W'(r_i) == r_rows - 1'b1) begin
                        n_i     = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain - 1'b1;
                if (r_drain == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_v || i_m_tready) begin
                    n_out_v    = 1'b1;
                    n_out_row  = r_i;
                    n_out_col  = r_k;
                    n_out_val  = cell_rd[r_k[KW-1:0]];
                    n_out_last = (DIM_W'(r_i) == r_rows - 1'b1) &&
                                 (DIM_W'(r_k) == r_cols - 1'b1);
                    if (DIM_W'(r_k) == r_cols - 1'b1) begin
                        n_k = '0;
                        n_i = r_i + 1'b1;
                        if (n_out_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reg_rows  <= 4'd8;
            r_reg_cols  <= 4'd8;
            r_reg_inner <= 4'd8;
            r_feed_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
        end else begin
            r_state  <= n_state;
            r_feed_v <= n_feed_v;
            r_out_v  <= n_out_v;
            r_i      <= n_i;
            r_k      <= n_k;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS:  r_reg_rows  <= i_cfg_data;
                    REG_COLS:  r_reg_cols  <= i_cfg_data;
                    REG_INNER: r_reg_inner <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_rows     <= n_rows;
        r_cols     <= n_cols;
        r_inner    <= n_inner;
        r_drain    <= n_drain;
        r_feed_i   <= r_i;
        r_feed_k   <= r_k;
        r_out_last <= n_out_last;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_val  <= n_out_val;
    end

    always_ff @(posedge i_clk) begin
        r_a_rd <= a_mem[{r_i[KW-1:0], r_k[KW-1:0]}];
        if (accept && in_ok && i_s_tuser == FN_LOAD_A) begin
            a_mem[{in_row[KW-1:0], in_col[KW-1:0]}] <= in_el;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out_val, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;

    a_feed_from_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_feed_v |-> $past(r_state) == S_FEED)
        else $error("feed request outside feed phase");

    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_DRAIN && r_state == S_DRAIN) |-> !r_feed_v)
        else $error("feed request during drain");

    a_start_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_IDLE && r_state != S_IDLE) |-> $past(i_s_tvalid))
        else $error("run started without a request");

endmodule
